FILE: rtl/core/gtg_pkg.sv
// ----------------------------------------------------------------------------
// gtg_pkg: shared types and constants of the go-to-goal controller
// Fixed-point widths, op and register codes, the CORDIC angle table and the
// sequencer state type.
// ----------------------------------------------------------------------------
package gtg_pkg;

   // Request op codes.
   localparam logic [1:0] OP_POSE   = 2'd0;
   localparam logic [1:0] OP_TARGET = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_CATCH_RADIUS = 2'd0;
   localparam logic [1:0] CSR_LINEAR_GAIN  = 2'd1;
   localparam logic [1:0] CSR_ANGULAR_GAIN = 2'd2;

   // Datapath widths: CORDIC x and y carry Q.8 offsets with gain growth,
   // z carries angles in Q.16 radians.
   localparam int XY_W  = 28;
   localparam int Z_W   = 20;
   localparam int DST_W = 18;
   localparam int ERR_W = 18;

   localparam logic signed [Z_W-1:0]   HALF_PI_Q16  = 20'sd102944;
   localparam logic signed [ERR_W-1:0] PI_Q13       = 18'sd25736;
   localparam logic signed [ERR_W-1:0] TWO_PI_Q13   = 18'sd51472;
   localparam logic signed [17:0]      INV_GAIN_Q16 = 18'sd39797;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CORDIC = 4'b0010,
      ST_SCALE  = 4'b0100,
      ST_CMD    = 4'b1000
   } state_type;

   // round(atan(2^-i) * 2^16)
   function automatic logic signed [Z_W-1:0] atan_q16(input logic [4:0] idx);
      logic signed [Z_W-1:0] val;
      case (idx)
         5'd0:    val = 20'sd51472;
         5'd1:    val = 20'sd30386;
         5'd2:    val = 20'sd16055;
         5'd3:    val = 20'sd8150;
         5'd4:    val = 20'sd4091;
         5'd5:    val = 20'sd2047;
         5'd6:    val = 20'sd1024;
         5'd7:    val = 20'sd512;
         5'd8:    val = 20'sd256;
         5'd9:    val = 20'sd128;
         5'd10:   val = 20'sd64;
         5'd11:   val = 20'sd32;
         5'd12:   val = 20'sd16;
         5'd13:   val = 20'sd8;
         5'd14:   val = 20'sd4;
         5'd15:   val = 20'sd2;
         5'd16:   val = 20'sd1;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

FILE: rtl/core/gtg_cordic.sv
// ----------------------------------------------------------------------------
// gtg_cordic: iterative CORDIC vectoring unit
// Takes the offset to the target, pre-rotates it into the right half plane
// and runs one shift-add micro-rotation per cycle. x ends as K times the
// distance and z as the bearing in Q.16 radians.
// ----------------------------------------------------------------------------
module gtg_cordic #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [16:0]              dx,
   input  logic signed [16:0]              dy,
   output logic                            done,
   output logic signed [gtg_pkg::XY_W-1:0] x_out,
   output logic signed [gtg_pkg::Z_W-1:0]  z_out
);

   localparam int ITER_W = $clog2(CORDIC_STEPS);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [ITER_W-1:0]               iter_ff, iter_in;
   logic signed [gtg_pkg::XY_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [gtg_pkg::Z_W-1:0]  z_ff, z_in;
   logic signed [gtg_pkg::XY_W-1:0] x0, y0, xs, ys;
   logic signed [gtg_pkg::Z_W-1:0]  step_ang;
   logic                            last_iter;

   assign x0 = {{3{dx[16]}}, dx, 8'd0};
   assign y0 = {{3{dy[16]}}, dy, 8'd0};
   assign xs = x_ff >>> iter_ff;
   assign ys = y_ff >>> iter_ff;
   assign step_ang  = gtg_pkg::atan_q16(5'(iter_ff));
   assign last_iter = (iter_ff == ITER_W'(CORDIC_STEPS - 1));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         iter_in = '0;
         if (x0 < 0) begin
            if (!y0[gtg_pkg::XY_W-1]) begin
               x_in = y0;
               y_in = -x0;
               z_in = gtg_pkg::HALF_PI_Q16;
            end else begin
               x_in = -y0;
               y_in = x0;
               z_in = -gtg_pkg::HALF_PI_Q16;
            end
         end else begin
            x_in = x0;
            y_in = y0;
            z_in = '0;
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + step_ang;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - step_ang;
         end
         iter_in = iter_ff + 1'b1;
         if (last_iter) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign done  = done_ff;
   assign x_out = x_ff;
   assign z_out = z_ff;

endmodule

FILE: rtl/core/go_to_goal_p_controller_unit.sv
// ----------------------------------------------------------------------------
// go_to_goal_p_controller_unit: go-to-goal proportional steering controller
// Keeps the latest pose and target and turns each control tick into speed and
// turn rate commands, or a catch report once the target is within the radius.
// ----------------------------------------------------------------------------
// A control tick with a pose and an active target is accepted and loads the
// CORDIC unit; that single shift-add unit runs the micro-rotations and reports
// done to the sequencer, then the distance is scaled and the heading error
// formed, and last the gains are applied and the result register filled.
// The request side stalls while a tick is in work. A finished result sits in
// its own register, so the next request is taken while it waits for transfer.
// Ticks without a pose or an active target give no result.
module go_to_goal_p_controller_unit #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic [15:0]        req_pos_x,
   input  logic [15:0]        req_pos_y,
   input  logic signed [15:0] req_heading,
   input  logic [15:0]        req_goal_x_in,
   input  logic [15:0]        req_goal_y_in,
   input  logic [7:0]         req_goal_id_in,
   input  logic               req_list_nonempty,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [19:0]        rsp_linear_speed,
   output logic signed [20:0] rsp_angular_rate,
   output logic               rsp_caught,
   output logic [7:0]         rsp_caught_id,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);

   localparam int DW = gtg_pkg::DST_W;
   localparam int EW = gtg_pkg::ERR_W;

   gtg_pkg::state_type state_ff, state_in;

   logic [15:0]        catch_radius_ff;
   logic [3:0]         linear_gain_ff, angular_gain_ff;
   logic [15:0]        own_x_ff, own_y_ff, goal_x_ff, goal_y_ff;
   logic signed [15:0] own_heading_ff;
   logic [7:0]         goal_id_ff;
   logic               pose_seen_ff, goal_active_ff, goal_active_in;

   logic [DW-1:0]        dist_ff;
   logic signed [EW-1:0] err_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [19:0]          lin_ff;
   logic signed [20:0]   ang_ff;
   logic                 caught_ff;
   logic [7:0]           caught_id_ff;

   logic req_take, rsp_take, tick_go, out_load, far;
   logic signed [16:0] dx, dy;
   logic cordic_done;
   logic signed [gtg_pkg::XY_W-1:0] cordic_x;
   logic signed [gtg_pkg::Z_W-1:0]  cordic_z;

   logic signed [44:0]   prod, prod_rnd;
   logic signed [gtg_pkg::Z_W-1:0] z_rnd;
   logic signed [EW-1:0] err_raw, err_wrap;
   logic [21:0]          lin_full;
   logic signed [22:0]   ang_full;
   logic [19:0]          lin_sat;
   logic signed [20:0]   ang_sat;

   assign req_stall = (state_ff != gtg_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign tick_go   = req_take && (req_op == gtg_pkg::OP_TICK)
                      && pose_seen_ff && goal_active_ff;
   assign out_load  = (state_ff == gtg_pkg::ST_CMD) && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready = 1'b1;

   assign dx = signed'({1'b0, goal_x_ff}) - signed'({1'b0, own_x_ff});
   assign dy = signed'({1'b0, goal_y_ff}) - signed'({1'b0, own_y_ff});

   gtg_cordic #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (tick_go),
      .dx    (dx),
      .dy    (dy),
      .done  (cordic_done),
      .x_out (cordic_x),
      .z_out (cordic_z)
   );

   // Distance is x / K with rounding; bearing goes from Q.16 to Q3.13.
   assign prod     = 45'(cordic_x) * 45'(gtg_pkg::INV_GAIN_Q16);
   assign prod_rnd = prod + 45'sd8388608;
   assign z_rnd    = cordic_z + 20'sd4;
   assign err_raw  = EW'(signed'(z_rnd[gtg_pkg::Z_W-1:3])) - EW'(own_heading_ff);

   always_comb begin
      err_wrap = err_raw;
      if (err_raw > gtg_pkg::PI_Q13) begin
         err_wrap = err_raw - gtg_pkg::TWO_PI_Q13;
      end else if (err_raw < -gtg_pkg::PI_Q13) begin
         err_wrap = err_raw + gtg_pkg::TWO_PI_Q13;
      end
   end

   assign far      = dist_ff > DW'(catch_radius_ff);
   assign lin_full = 22'(linear_gain_ff) * 22'(dist_ff);
   assign ang_full = 23'(signed'({1'b0, angular_gain_ff})) * 23'(err_ff);
   assign lin_sat  = (|lin_full[21:20]) ? 20'hFFFFF : lin_full[19:0];

   always_comb begin
      if (ang_full > 23'sd1048575) begin
         ang_sat = 21'sh0FFFFF;
      end else if (ang_full < -23'sd1048576) begin
         ang_sat = 21'sh100000;
      end else begin
         ang_sat = ang_full[20:0];
      end
   end

   always_comb begin
      state_in       = state_ff;
      goal_active_in = goal_active_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_take;
      case (state_ff)
         gtg_pkg::ST_IDLE: begin
            if (tick_go) begin
               state_in = gtg_pkg::ST_CORDIC;
            end
            if (req_take && (req_op == gtg_pkg::OP_TARGET) && req_list_nonempty) begin
               goal_active_in = 1'b1;
            end
         end
         gtg_pkg::ST_CORDIC: begin
            if (cordic_done) begin
               state_in = gtg_pkg::ST_SCALE;
            end
         end
         gtg_pkg::ST_SCALE: begin
            state_in = gtg_pkg::ST_CMD;
         end
         gtg_pkg::ST_CMD: begin
            if (out_load) begin
               state_in     = gtg_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               if (!far) begin
                  goal_active_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = gtg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= gtg_pkg::ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         pose_seen_ff    <= 1'b0;
         goal_active_ff  <= 1'b0;
         own_x_ff        <= '0;
         own_y_ff        <= '0;
         own_heading_ff  <= '0;
         goal_x_ff       <= '0;
         goal_y_ff       <= '0;
         goal_id_ff      <= '0;
         catch_radius_ff <= 16'd2048;
         linear_gain_ff  <= 4'd2;
         angular_gain_ff <= 4'd6;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         goal_active_ff <= goal_active_in;
         if (req_take && (req_op == gtg_pkg::OP_POSE)) begin
            own_x_ff       <= req_pos_x;
            own_y_ff       <= req_pos_y;
            own_heading_ff <= req_heading;
            pose_seen_ff   <= 1'b1;
         end
         if (req_take && (req_op == gtg_pkg::OP_TARGET) && req_list_nonempty) begin
            goal_x_ff  <= req_goal_x_in;
            goal_y_ff  <= req_goal_y_in;
            goal_id_ff <= req_goal_id_in;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               gtg_pkg::CSR_CATCH_RADIUS: catch_radius_ff <= csr_data;
               gtg_pkg::CSR_LINEAR_GAIN:  linear_gain_ff  <= csr_data[3:0];
               gtg_pkg::CSR_ANGULAR_GAIN: angular_gain_ff <= csr_data[3:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == gtg_pkg::ST_SCALE) begin
         dist_ff <= prod_rnd[24+DW-1:24];
         err_ff  <= err_wrap;
      end
      if (out_load) begin
         lin_ff       <= far ? lin_sat : '0;
         ang_ff       <= far ? ang_sat : '0;
         caught_ff    <= !far;
         caught_id_ff <= far ? 8'd0 : goal_id_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_linear_speed = lin_ff;
   assign rsp_angular_rate = ang_ff;
   assign rsp_caught       = caught_ff;
   assign rsp_caught_id    = caught_id_ff;

   // The CORDIC unit only finishes while the sequencer waits for it.
   a_done_in_cordic: assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> (state_ff == gtg_pkg::ST_CORDIC))
      else $error("CORDIC finished outside its sequencer state");

   // A catch report carries zero speed commands.
   a_catch_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && caught_ff) |-> (lin_ff == '0 && ang_ff == '0))
      else $error("catch result with nonzero command");

   // A result without a catch reports id zero.
   a_id_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !caught_ff) |-> (caught_id_ff == '0))
      else $error("caught id set without a catch");

   // Catching the target drops it.
   a_catch_drops: assert property (@(posedge clock) disable iff (reset)
      (out_load && !far) |=> !goal_active_ff)
      else $error("target still active after a catch");

endmodule

FILE: tb/sv/go_to_goal_p_controller_unit_tb.sv
// ----------------------------------------------------------------------------
// go_to_goal_p_controller_unit_tb: self-checking bench of the steering unit
// Drives pose, target and tick requests with random gaps and stalls. A
// scoreboard keeps its own pose, target and register copy, predicts each
// speed, turn rate or catch command, and compares every returned command
// field by field.
// ----------------------------------------------------------------------------
module go_to_goal_p_controller_unit_tb;

   localparam int CORDIC_STEPS = 16;
   localparam int SETTLE_CYCLES = CORDIC_STEPS + 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int ITEMS_PER_PHASE = 250;
   localparam int NUM_PHASES = 5;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam longint SPEED_MAX = 1048575;
   localparam longint RATE_MAX = 1048575;
   localparam longint RATE_MIN = -1048576;
   localparam int HEADING_LIMIT = 25736;
   localparam longint MICRO_ANGLE [0:23] = '{
      51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2,
      1, 0, 0, 0, 0, 0, 0, 0
   };

   typedef struct {
      logic [1:0]         op;
      logic [15:0]        pos_x;
      logic [15:0]        pos_y;
      logic signed [15:0] heading;
      logic [15:0]        goal_x;
      logic [15:0]        goal_y;
      logic [7:0]         goal_id;
      logic               list_nonempty;
   } request_type;

   typedef struct {
      logic [19:0]        linear_speed;
      logic signed [20:0] angular_rate;
      logic               caught;
      logic [7:0]         caught_id;
   } command_type;

   class steering_scoreboard_type;
      command_type        command_q[$];
      int                 errors;
      logic [15:0]        radius;
      logic [3:0]         lin_gain;
      logic [3:0]         ang_gain;
      logic [15:0]        own_x;
      logic [15:0]        own_y;
      logic signed [15:0] own_heading;
      logic               pose_seen;
      logic [15:0]        goal_x;
      logic [15:0]        goal_y;
      logic [7:0]         goal_id;
      logic               goal_active;

      function new();
         errors = 0;
         radius = 16'd2048;
         lin_gain = 4'd2;
         ang_gain = 4'd6;
         own_x = '0;
         own_y = '0;
         own_heading = '0;
         pose_seen = 1'b0;
         goal_x = '0;
         goal_y = '0;
         goal_id = '0;
         goal_active = 1'b0;
      endfunction

      function int pending();
         return command_q.size();
      endfunction

      function void write_register(input logic [1:0] idx, input logic [15:0] val);
         case (idx)
            gtg_pkg::CSR_CATCH_RADIUS: radius = val;
            gtg_pkg::CSR_LINEAR_GAIN:  lin_gain = val[3:0];
            gtg_pkg::CSR_ANGULAR_GAIN: ang_gain = val[3:0];
            default: ;
         endcase
      endfunction

      function void note_request(input request_type r);
         longint x0, y0, x, y, z, xs, ys, reach, bearing, err, lin, ang;
         command_type c;
         int i;
         case (r.op)
            gtg_pkg::OP_POSE: begin
               own_x = r.pos_x;
               own_y = r.pos_y;
               own_heading = r.heading;
               pose_seen = 1'b1;
            end
            gtg_pkg::OP_TARGET: if (r.list_nonempty) begin
               goal_x = r.goal_x;
               goal_y = r.goal_y;
               goal_id = r.goal_id;
               goal_active = 1'b1;
            end
            gtg_pkg::OP_TICK: if (pose_seen && goal_active) begin
               x0 = (longint'(goal_x) - longint'(own_x)) * 256;
               y0 = (longint'(goal_y) - longint'(own_y)) * 256;
               // Left half-plane vectors are turned by a quarter turn first.
               if (x0 < 0) begin
                  if (y0 >= 0) begin
                     x = y0;
                     y = -x0;
                     z = longint'(gtg_pkg::HALF_PI_Q16);
                  end else begin
                     x = -y0;
                     y = x0;
                     z = -longint'(gtg_pkg::HALF_PI_Q16);
                  end
               end else begin
                  x = x0;
                  y = y0;
                  z = 0;
               end
               for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
                  xs = x >>> i;
                  ys = y >>> i;
                  if (y > 0) begin
                     x += ys;
                     y -= xs;
                     z += MICRO_ANGLE[i];
                  end else begin
                     x -= ys;
                     y += xs;
                     z -= MICRO_ANGLE[i];
                  end
               end
               reach = (x * longint'(gtg_pkg::INV_GAIN_Q16) + (longint'(1) << 23)) >>> 24;
               if (reach > longint'(radius)) begin
                  lin = longint'(lin_gain) * reach;
                  if (lin > SPEED_MAX) lin = SPEED_MAX;
                  if (lin < 0) lin = 0;
                  bearing = (z + 4) >>> 3;
                  err = bearing - longint'(own_heading);
                  if (err > longint'(gtg_pkg::PI_Q13))
                     err -= longint'(gtg_pkg::TWO_PI_Q13);
                  else if (err < -longint'(gtg_pkg::PI_Q13))
                     err += longint'(gtg_pkg::TWO_PI_Q13);
                  ang = longint'(ang_gain) * err;
                  if (ang > RATE_MAX) ang = RATE_MAX;
                  if (ang < RATE_MIN) ang = RATE_MIN;
                  c.linear_speed = lin[19:0];
                  c.angular_rate = ang[20:0];
                  c.caught = 1'b0;
                  c.caught_id = '0;
               end else begin
                  c.linear_speed = '0;
                  c.angular_rate = '0;
                  c.caught = 1'b1;
                  c.caught_id = goal_id;
                  goal_active = 1'b0;
               end
               command_q.insert(command_q.size(), c);
            end
            default: ;
         endcase
      endfunction

      function void check_response(input command_type got);
         command_type exp;
         if (command_q.size() == 0) begin
            $display("%0t: unexpected command, speed %0d rate %0d caught %0b id %0d",
                     $time, got.linear_speed, got.angular_rate, got.caught, got.caught_id);
            errors++;
            return;
         end
         exp = command_q.pop_front();
         if (got.linear_speed !== exp.linear_speed) begin
            $display("%0t: linear_speed expected %0d, got %0d",
                     $time, exp.linear_speed, got.linear_speed);
            errors++;
         end
         if (got.angular_rate !== exp.angular_rate) begin
            $display("%0t: angular_rate expected %0d, got %0d",
                     $time, exp.angular_rate, got.angular_rate);
            errors++;
         end
         if (got.caught !== exp.caught) begin
            $display("%0t: caught expected %0b, got %0b", $time, exp.caught, got.caught);
            errors++;
         end
         if (got.caught_id !== exp.caught_id) begin
            $display("%0t: caught_id expected %0d, got %0d",
                     $time, exp.caught_id, got.caught_id);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_op = '0;
   logic [15:0]        req_pos_x = '0;
   logic [15:0]        req_pos_y = '0;
   logic signed [15:0] req_heading = '0;
   logic [15:0]        req_goal_x_in = '0;
   logic [15:0]        req_goal_y_in = '0;
   logic [7:0]         req_goal_id_in = '0;
   logic               req_list_nonempty = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [19:0]        rsp_linear_speed;
   logic signed [20:0] rsp_angular_rate;
   logic               rsp_caught;
   logic [7:0]         rsp_caught_id;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [15:0]        csr_data = '0;

   steering_scoreboard_type board;
   int req_idle_pct = 10;
   int rsp_idle_pct = 10;
   bit hold_off_req = 1'b0;
   int sent_items = 0;

   go_to_goal_p_controller_unit #(.CORDIC_STEPS(CORDIC_STEPS)) DUT (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic request_type random_request(input logic [1:0] op);
      request_type r;
      int h;
      h = int'($urandom_range(0, 2 * HEADING_LIMIT)) - HEADING_LIMIT;
      r.op = op;
      r.pos_x = 16'($urandom);
      r.pos_y = 16'($urandom);
      r.heading = h[15:0];
      r.goal_x = 16'($urandom);
      r.goal_y = 16'($urandom);
      r.goal_id = 8'($urandom);
      r.list_nonempty = 1'($urandom);
      return r;
   endfunction

   function automatic request_type pose_req(input logic [15:0] x, input logic [15:0] y,
                                            input logic signed [15:0] h);
      request_type r;
      r = random_request(gtg_pkg::OP_POSE);
      r.pos_x = x;
      r.pos_y = y;
      r.heading = h;
      return r;
   endfunction

   function automatic request_type target_req(input logic [15:0] x, input logic [15:0] y,
                                              input logic [7:0] id, input logic nonempty);
      request_type r;
      r = random_request(gtg_pkg::OP_TARGET);
      r.goal_x = x;
      r.goal_y = y;
      r.goal_id = id;
      r.list_nonempty = nonempty;
      return r;
   endfunction

   function automatic logic [15:0] corner();
      return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
   endfunction

   function automatic logic [15:0] near(input logic [15:0] base, input int span);
      int v;
      v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[15:0];
   endfunction

   // The payload holds until the transfer; valid stays up into the next request.
   task automatic send_request(input request_type r);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_op <= 2'($urandom);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_op <= r.op;
      req_pos_x <= r.pos_x;
      req_pos_y <= r.pos_y;
      req_heading <= r.heading;
      req_goal_x_in <= r.goal_x;
      req_goal_y_in <= r.goal_y;
      req_goal_id_in <= r.goal_id;
      req_list_nonempty <= r.list_nonempty;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(r);
      if (r.op != OP_UNUSED) sent_items++;
   endtask

   // Pauses the requests until every command is back and any silent tick is done.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_register(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_directed();
      send_request(random_request(gtg_pkg::OP_TICK));
      send_request(target_req(16'h1234, 16'h4321, 8'd7, 1'b0));
      send_request(random_request(gtg_pkg::OP_TICK));
      send_request(pose_req(16'h0000, 16'h0000, 16'sd0));
      send_request(random_request(gtg_pkg::OP_TICK));
      send_request(random_request(OP_UNUSED));
      send_request(target_req(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1));
      send_request(random_request(gtg_pkg::OP_TICK));
      send_request(pose_req(16'hFFFF, 16'h0000, -16'sd25736));
      send_request(random_request(gtg_pkg::OP_TICK));
      send_request(pose_req(16'hFFFF, 16'hFFFF, 16'sd25736));
      send_request(random_request(gtg_pkg::OP_TICK));
      send_request(random_request(gtg_pkg::OP_TICK));
      send_request(target_req(16'h0000, 16'h0000, 8'h00, 1'b1));
      send_request(pose_req(16'hFFFF, 16'hFFFF, -16'sd25736));
      send_request(random_request(gtg_pkg::OP_TICK));
      send_request(pose_req(16'hFFFF, 16'h0000, 16'sd25736));
      send_request(random_request(gtg_pkg::OP_TICK));
      send_request(target_req(16'h8000, 16'h8000, 8'h5A, 1'b0));
      send_request(random_request(gtg_pkg::OP_TICK));
      send_request(pose_req(16'h0000, 16'h0000, 16'sd0));
      send_request(random_request(gtg_pkg::OP_TICK));
   endtask

   // A target, up to three poses each with a steering tick, then a pose near the goal and one or two ticks.
   task automatic run_chase();
      request_type r;
      logic [15:0] gx, gy;
      int span;
      r = target_req(16'($urandom), 16'($urandom), 8'($urandom), 1'b1);
      if ($urandom_range(0, 7) == 0) begin
         r.goal_x = corner();
         r.goal_y = corner();
      end
      send_request(r);
      gx = r.goal_x;
      gy = r.goal_y;
      repeat ($urandom_range(0, 3)) begin
         r = random_request(gtg_pkg::OP_POSE);
         if ($urandom_range(0, 7) == 0) begin
            r.pos_x = corner();
            r.pos_y = corner();
         end else if ($urandom_range(0, 1) == 0) begin
            r.pos_x = near(gx, 8192);
            r.pos_y = near(gy, 8192);
         end
         send_request(r);
         send_request(random_request(gtg_pkg::OP_TICK));
      end
      case ($urandom_range(0, 3))
         0: span = 0;
         1: span = 16;
         2: span = 1024;
         default: span = 4096;
      endcase
      r = random_request(gtg_pkg::OP_POSE);
      r.pos_x = near(gx, span);
      r.pos_y = near(gy, span);
      send_request(r);
      send_request(random_request(gtg_pkg::OP_TICK));
      if ($urandom_range(0, 1) == 0) send_request(random_request(gtg_pkg::OP_TICK));
   endtask

   task automatic configure_phase(input int phase);
      case (phase)
         1: begin
            write_csr(gtg_pkg::CSR_CATCH_RADIUS, 16'hFFFF);
            write_csr(gtg_pkg::CSR_LINEAR_GAIN, 16'hFFFF);
            write_csr(gtg_pkg::CSR_ANGULAR_GAIN, 16'hFFFF);
         end
         2: begin
            write_csr(gtg_pkg::CSR_CATCH_RADIUS, 16'h0000);
            write_csr(gtg_pkg::CSR_LINEAR_GAIN, 16'h0000);
            write_csr(gtg_pkg::CSR_ANGULAR_GAIN, 16'h0000);
         end
         3: begin
            write_csr(gtg_pkg::CSR_CATCH_RADIUS, 16'($urandom_range(0, 8192)));
            write_csr(gtg_pkg::CSR_LINEAR_GAIN, 16'($urandom));
            write_csr(gtg_pkg::CSR_ANGULAR_GAIN, 16'($urandom));
         end
         4: begin
            write_csr(CSR_UNUSED, 16'($urandom));
            write_csr(gtg_pkg::CSR_CATCH_RADIUS, 16'd2048);
            write_csr(gtg_pkg::CSR_LINEAR_GAIN, 16'($urandom_range(1, 15)));
            write_csr(gtg_pkg::CSR_ANGULAR_GAIN, 16'($urandom));
         end
         default: ;
      endcase
   endtask

   // Receiver stall pattern, with one long hold-off on request.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
         end
      end
   end

   initial begin
      command_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.linear_speed = rsp_linear_speed;
            got.angular_rate = rsp_angular_rate;
            got.caught = rsp_caught;
            got.caught_id = rsp_caught_id;
            board.check_response(got);
         end
      end
   end

   // Ends the run when no transfer of any kind happens for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int phase_end;
      board = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         drain();
         configure_phase(phase);
         req_idle_pct = (phase == 1) ? 0 : 10;
         rsp_idle_pct = (phase == 1) ? 0 : 10;
         if (phase == 2) hold_off_req = 1'b1;
         phase_end = sent_items + ITEMS_PER_PHASE;
         while (sent_items < phase_end) begin
            if ($urandom_range(0, 3) != 0)
               run_chase();
            else
               send_request(random_request(2'($urandom_range(0, 3))));
            if ($urandom_range(0, 99) == 0) drain();
         end
      end
      drain();
      if (board.errors == 0 && board.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/gtg_pkg.sv
rtl/core/gtg_cordic.sv
rtl/core/go_to_goal_p_controller_unit.sv
tb/sv/go_to_goal_p_controller_unit_tb.sv
